// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkset assertion failed");

// Next-cycle implication, disabled while in reset.
`define HK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkset assertion failed");

`endif

// ===== hdl/hkset_pkg.sv =====
// Package: constants and types of the hashed key set.
`default_nettype none
package hkset_pkg;
  localparam int CAPACITY  = 1024;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;
  localparam int KEY_W     = 64;
  localparam int HALF_W    = 32;
  localparam int DEV_W     = 32;
  localparam int INO_W     = 64;
  localparam int MIX_SHIFT = 29;
  localparam int LOAD_NUM  = 7;
  localparam int LOAD_DEN  = 10;
  // an insert is refused once this many keys are held
  localparam int MAX_KEYS_I = (CAPACITY * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN - 1;

  localparam logic [KEY_W-1:0]  GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [HALF_W-1:0] GOLDEN_LO   = GOLDEN_MULT[HALF_W-1:0];
  localparam logic [HALF_W-1:0] GOLDEN_HI   = GOLDEN_MULT[KEY_W-1:HALF_W];
  localparam logic [CNT_W-1:0]  MAX_KEYS    = CNT_W'(MAX_KEYS_I);

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic found;
    logic inserted;
    logic table_full;
  } result_t;
endpackage
`default_nettype wire

// ===== hdl/hkset_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hkset_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/hkset_keygen.sv =====
// Key former: 64-bit golden-ratio multiply over a shared 32x32 multiplier, then mix.
`default_nettype none
module hkset_keygen (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [hkset_pkg::DEV_W-1:0] device_id,
  input  wire logic [hkset_pkg::INO_W-1:0] inode_number,
  output logic                           key_valid,
  output hkset_pkg::key_t                key
);
  import hkset_pkg::*;

  localparam logic [2:0] KG_IDLE = 3'd0;
  localparam logic [2:0] KG_LO   = 3'd1;
  localparam logic [2:0] KG_CRH  = 3'd2;
  localparam logic [2:0] KG_CRL  = 3'd3;
  localparam logic [2:0] KG_MIX  = 3'd4;

  logic [2:0]        step_r, step_nxt;
  logic              vld_r, vld_nxt;
  key_t              x_r, acc_r, key_r;
  logic [HALF_W-1:0] crh_r, crl_r;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [KEY_W-1:0]  prod;
  logic [HALF_W-1:0] hisum;
  key_t              mrg, mixed, key_nxt;

  assign mul_a = (step_r == KG_CRH) ? x_r[KEY_W-1:HALF_W] : x_r[HALF_W-1:0];
  assign mul_b = (step_r == KG_CRL) ? GOLDEN_HI : GOLDEN_LO;
  assign prod  = KEY_W'(mul_a) * KEY_W'(mul_b);

  assign hisum   = crh_r + crl_r;
  assign mrg     = acc_r + {hisum, {HALF_W{1'b0}}};
  assign mixed   = mrg ^ (mrg >> MIX_SHIFT);
  assign key_nxt = (mixed == '0) ? KEY_W'(1) : mixed;

  always_comb begin
    step_nxt = step_r;
    vld_nxt  = 1'b0;
    case (step_r)
      KG_IDLE: if (start) step_nxt = KG_LO;
      KG_LO:   step_nxt = KG_CRH;
      KG_CRH:  step_nxt = KG_CRL;
      KG_CRL:  step_nxt = KG_MIX;
      KG_MIX: begin
        step_nxt = KG_IDLE;
        vld_nxt  = 1'b1;
      end
      default: step_nxt = KG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= KG_IDLE;
      vld_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      vld_r  <= vld_nxt;
    end
    if (step_r == KG_IDLE && start) begin
      x_r <= {device_id, {HALF_W{1'b0}}} ^ inode_number;
    end
    if (step_r == KG_LO)  acc_r <= prod;
    if (step_r == KG_CRH) crh_r <= prod[HALF_W-1:0];
    if (step_r == KG_CRL) crl_r <= prod[HALF_W-1:0];
    if (step_r == KG_MIX) key_r <= key_nxt;
  end

  assign key_valid = vld_r;
  assign key       = key_r;
endmodule
`default_nettype wire

// ===== hdl/hashed_key_set_linear_probe_unit.sv =====
// Top level: hashed key set with linear probing over a slot RAM.
`default_nettype none
`include "assert_macros.svh"
// After reset the slot RAM is cleared in a pass over every slot (one slot per cycle), during
// which in_ready stays low. One request is handled at a time: the key is formed on the shared
// 32x32 multiplier (steps LO, CRH, CRL, MIX), the home slot is read, then the slots are probed
// in turn (one RAM read per cycle), and the result is handed to the output register, waiting
// while a held result is not yet taken. The output register holds a result while the next
// request is accepted. Inserts beyond 716 keys (70% load limit) are refused with table_full.
module hashed_key_set_linear_probe_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_req_type,
  input  wire logic [hkset_pkg::DEV_W-1:0] in_device_id,
  input  wire logic [hkset_pkg::INO_W-1:0] in_inode_number,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic                             out_inserted,
  output logic                             out_table_full
);
  import hkset_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  idx_t       clr_idx_r, clr_idx_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       n_r, n_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       req_ins_r, req_ins_nxt;
  result_t    res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r, out_res_nxt;

  logic       accept;
  logic       kg_valid;
  key_t       kg_key;
  logic       ram_we;
  idx_t       ram_waddr, ram_raddr;
  key_t       ram_wdata, ram_rdata;
  logic       slot_hit, slot_empty, probe_done;
  logic       ins_we;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  hkset_keygen u_keygen (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (accept),
    .device_id    (in_device_id),
    .inode_number (in_inode_number),
    .key_valid    (kg_valid),
    .key          (kg_key)
  );

  hkset_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_hit   = (ram_rdata == kg_key);
  assign slot_empty = (ram_rdata == '0);
  assign probe_done = slot_hit || slot_empty || (n_r == '1);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    req_ins_nxt   = req_ins_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = kg_key;
    ram_raddr     = idx_r;
    ins_we        = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          req_ins_nxt = in_req_type;
          state_nxt   = ST_HASH;
        end
      end
      ST_HASH: begin
        ram_raddr = kg_key[IDX_W-1:0];
        if (kg_valid) begin
          idx_nxt   = kg_key[IDX_W-1:0];
          n_nxt     = '0;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        ram_raddr = idx_r + 1'b1;
        if (probe_done) begin
          res_nxt.found      = slot_hit;
          res_nxt.inserted   = 1'b0;
          res_nxt.table_full = 1'b0;
          if (req_ins_r && !slot_hit) begin
            if (cnt_r >= MAX_KEYS || !slot_empty) begin
              res_nxt.table_full = 1'b1;
            end else begin
              ins_we           = 1'b1;
              ram_we           = 1'b1;
              cnt_nxt          = cnt_r + 1'b1;
              res_nxt.inserted = 1'b1;
            end
          end
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
          n_nxt   = n_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    req_ins_r <= req_ins_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_res_r.found;
  assign out_inserted   = out_res_r.inserted;
  assign out_table_full = out_res_r.table_full;

  `HK_ASSERT_IMPLY(a_cnt_limit, clk, rst_n, 1'b1, cnt_r <= MAX_KEYS)
  `HK_ASSERT_IMPLY(a_one_flag, clk, rst_n, out_valid,
                   $countones({out_found, out_inserted, out_table_full}) <= 1)
  `HK_ASSERT_NEXT(a_ins_count, clk, rst_n, ins_we, cnt_r == $past(cnt_r) + 1'b1)
  `HK_ASSERT_IMPLY(a_no_req_clear, clk, rst_n, state_r == ST_CLEAR, !in_ready)
endmodule
`default_nettype wire
